[rtl/rad_pkg.sv]
`default_nettype none
package rad_pkg;

  localparam int DataW      = 32;
  localparam int DepthDflt  = 8;

  typedef enum logic [1:0] {
    CMD_INS_REAR  = 2'd0,
    CMD_INS_FRONT = 2'd1,
    CMD_DEL_FRONT = 2'd2,
    CMD_DEL_REAR  = 2'd3
  } rad_cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } rad_status_t;

  localparam logic ModeInRestr  = 1'b0;
  localparam logic ModeOutRestr = 1'b1;

  // Per-cycle command broadcast along the cell row
  typedef struct packed {
    logic ins_rear;
    logic ins_front;
  } rad_cell_ctl_t;

endpackage
`default_nettype wire

[rtl/rad_cell.sv]
`default_nettype none
module rad_cell #(
  parameter int DEPTH = rad_pkg::DepthDflt,
  parameter int IDX   = 0
) (
  input  wire logic                       clk,
  input  wire rad_pkg::rad_cell_ctl_t     ctl,
  input  wire logic [$clog2(DEPTH)-1:0]   front_pos,
  input  wire logic [$clog2(DEPTH)-1:0]   end_pos,
  input  wire logic [$clog2(DEPTH)-1:0]   sel_pos,
  input  wire logic [rad_pkg::DataW-1:0]  value,
  input  wire logic [rad_pkg::DataW-1:0]  left_data,
  output logic      [rad_pkg::DataW-1:0]  data,
  output logic      [rad_pkg::DataW-1:0]  rd_data
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] MyPos = PW'(IDX);

  logic [rad_pkg::DataW-1:0] data_r;
  logic [rad_pkg::DataW-1:0] data_nxt;
  logic                      load;
  logic                      shift;

  always_comb begin
    load  = (ctl.ins_rear && (MyPos == end_pos)) ||
            (ctl.ins_front && (MyPos == front_pos));
    // front insert pushes everything from front..rear one slot toward the rear
    shift = ctl.ins_front && (MyPos > front_pos) && (MyPos <= end_pos);
    if (load) begin
      data_nxt = value;
    end else if (shift) begin
      data_nxt = left_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (MyPos == sel_pos) ? data_r : '0;

endmodule
`default_nettype wire

[rtl/restricted_array_deque.sv]
`default_nettype none
// Double-ended queue over a row of DEPTH storage cells with front/rear
// positions. Each item is applied to the cell row at the accept edge (a front
// insert shifts all stored cells one slot rearward in parallel) and its result
// sits in an output register, so a new item is taken every cycle while
// out_ready keeps up. The queue reports full once the rear reaches the last
// cell, even if cells before the front are free. cfg_wr_data selects the
// restriction: 0 refuses front inserts, 1 refuses rear deletes; a refused
// item returns status 3 and changes nothing.
module restricted_array_deque #(
  parameter int DEPTH = rad_pkg::DepthDflt
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_cmd,
  input  wire logic signed [rad_pkg::DataW-1:0]  in_item_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             out_status,
  output logic signed [rad_pkg::DataW-1:0]       out_removed_value
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LastPos = PW'(DEPTH - 1);

  logic                        mode_r;
  logic [PW-1:0]               front_r, front_nxt;
  logic [PW-1:0]               rear_r, rear_nxt;
  logic                        empty_r, empty_nxt;
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [rad_pkg::DataW-1:0]   out_removed_r;

  rad_pkg::rad_cmd_t           cmd;
  rad_pkg::rad_status_t        status;
  rad_pkg::rad_cell_ctl_t      ctl;
  logic                        accept;
  logic                        full;
  logic                        refused;
  logic [PW-1:0]               end_pos;
  logic [PW-1:0]               sel_pos;
  logic [rad_pkg::DataW-1:0]   removed;
  logic [rad_pkg::DataW-1:0]   rd_any;

  logic [rad_pkg::DataW-1:0]   cell_data [DEPTH];
  logic [rad_pkg::DataW-1:0]   cell_rd   [DEPTH];

  assign cmd      = rad_pkg::rad_cmd_t'(in_cmd);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = !empty_r && (rear_r == LastPos);
  assign refused  = ((cmd == rad_pkg::CMD_INS_FRONT) && (mode_r == rad_pkg::ModeInRestr)) ||
                    ((cmd == rad_pkg::CMD_DEL_REAR) && (mode_r == rad_pkg::ModeOutRestr));
  assign end_pos  = empty_r ? '0 : rear_r + PW'(1);
  assign sel_pos  = (cmd == rad_pkg::CMD_DEL_FRONT) ? front_r : rear_r;

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    empty_nxt = empty_r;
    status    = rad_pkg::ST_DONE;
    removed   = '0;
    ctl       = '0;
    if (refused) begin
      status = rad_pkg::ST_REFUSED;
    end else begin
      unique case (cmd) inside
        rad_pkg::CMD_INS_REAR, rad_pkg::CMD_INS_FRONT: begin
          if (full) begin
            status = rad_pkg::ST_FULL;
          end else begin
            ctl.ins_rear  = (cmd == rad_pkg::CMD_INS_REAR);
            ctl.ins_front = (cmd == rad_pkg::CMD_INS_FRONT);
            rear_nxt      = end_pos;
            empty_nxt     = 1'b0;
          end
        end
        rad_pkg::CMD_DEL_FRONT: begin
          if (empty_r) begin
            status = rad_pkg::ST_EMPTY;
          end else begin
            removed = rd_any;
            if (front_r >= rear_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              front_nxt = front_r + PW'(1);
            end
          end
        end
        rad_pkg::CMD_DEL_REAR: begin
          if (empty_r) begin
            status = rad_pkg::ST_EMPTY;
          end else begin
            removed = rd_any;
            if (rear_r <= front_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              rear_nxt = rear_r - PW'(1);
            end
          end
        end
        default: begin
          status = rad_pkg::ST_REFUSED;
        end
      endcase
    end
    // drop the cell command unless the item is taken this cycle
    if (!accept) begin
      ctl = '0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rad_cell #(
      .DEPTH(DEPTH),
      .IDX  (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .front_pos(front_r),
      .end_pos  (end_pos),
      .sel_pos  (sel_pos),
      .value    (in_item_value),
      .left_data((i == 0) ? in_item_value : cell_data[(i == 0) ? 0 : i - 1]),
      .data     (cell_data[i]),
      .rd_data  (cell_rd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rad_pkg::ModeInRestr;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (accept) begin
        front_r     <= front_nxt;
        rear_r      <= rear_nxt;
        empty_r     <= empty_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status;
      out_removed_r <= removed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;

endmodule
`default_nettype wire
